### hw/rtl/nearest_center_pixel_classifier_assert.svh
// assertion macros for the nearest center pixel classifier
// expects clk and rst_n in the scope that uses them
`ifndef NEAREST_CENTER_PIXEL_CLASSIFIER_ASSERT_SVH
`define NEAREST_CENTER_PIXEL_CLASSIFIER_ASSERT_SVH

// clocked assertion, held off during reset
`define NCPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define NCPC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/ncpc_pkg.sv
// shared types and constants for the nearest center pixel classifier
// no dependencies
package ncpc_pkg;

    localparam int MAX_CENTERS  = 16;
    localparam int IDX_W        = $clog2(MAX_CENTERS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int FEATURE_DIMS = 5;
    localparam int DIM_W        = 3;
    localparam int FEAT_W       = 34;
    localparam int DIST_W       = 64;
    localparam int DIV_NUM_W    = 34;
    localparam int DIV_DEN_W    = 17;
    localparam int DIST_WAIT    = FEATURE_DIMS + 1;

    // feature components
    localparam logic [DIM_W-1:0] DIM_BLUE  = 3'd0;
    localparam logic [DIM_W-1:0] DIM_GREEN = 3'd1;
    localparam logic [DIM_W-1:0] DIM_RED   = 3'd2;
    localparam logic [DIM_W-1:0] DIM_X     = 3'd3;
    localparam logic [DIM_W-1:0] DIM_Y     = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_COLOR_SCALE   = 3'd0;
    localparam logic [2:0] REG_SPATIAL_SCALE = 3'd1;
    localparam logic [2:0] REG_FRAME_WIDTH   = 3'd2;
    localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_CENTER_COUNT  = 3'd4;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_LOAD  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_DIST,
        S_CHAIN,
        S_OUT_DIV,
        S_OUT
    } state_t;

    // feature component broadcast to all cells
    typedef struct packed {
        logic                     valid;
        logic                     clr;
        logic [DIM_W-1:0]         dim;
        logic signed [FEAT_W-1:0] feat;
    } feed_t;

    // running best candidate handed along the chain
    typedef struct packed {
        logic               valid;
        logic [DIST_W-1:0]  score;
        logic [IDX_W-1:0]   idx;
        logic signed [31:0] blue;
        logic signed [31:0] green;
        logic signed [31:0] red;
    } chain_t;

endpackage

### hw/rtl/ncpc_div.sv
// restoring divider, one quotient bit per cycle
// depends on ncpc_pkg
module ncpc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ncpc_pkg::DIV_NUM_W-1:0] num,
    input  logic [ncpc_pkg::DIV_DEN_W-1:0] den,
    output logic                          done,
    output logic [ncpc_pkg::DIV_NUM_W-1:0] quo
);
    import ncpc_pkg::*;

    localparam int STEP_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;

    // one shift and subtract step
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        if (trial >= {1'b0, den_reg})
        begin
            rem_next = diff[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

### hw/rtl/ncpc_cell.sv
// one center cell: holds a center, accumulates its distance, compares on the chain
// depends on ncpc_pkg
module ncpc_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ncpc_pkg::IDX_W-1:0]  cell_id,
    input  logic [ncpc_pkg::CNT_W-1:0]  n_eff,
    input  logic                        wr_en,
    input  logic [ncpc_pkg::DIM_W-1:0]  wr_comp,
    input  logic signed [31:0]          wr_value,
    input  ncpc_pkg::feed_t             feed,
    input  logic                        chain_en,
    input  ncpc_pkg::chain_t            chain_in,
    output ncpc_pkg::chain_t            chain_out
);
    import ncpc_pkg::*;

    logic signed [31:0]       center_reg [FEATURE_DIMS];
    logic [31:0]              mag_reg;
    logic [DIST_W-1:0]        sq_reg;
    logic [DIST_W-1:0]        acc_reg;
    logic                     v1_reg, v2_reg;
    chain_t                   chain_reg;
    logic signed [FEAT_W-1:0] diff;
    logic [FEAT_W-1:0]        mag;
    logic [DIST_W:0]          acc_sum;
    logic                     take_own;
    chain_t                   own;

    // center components
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            center_reg[wr_comp] <= wr_value;
        end
    end

    // absolute difference of one component
    always_comb
    begin
        diff = feed.feat - FEAT_W'(center_reg[feed.dim]);
        mag  = diff[FEAT_W-1] ? FEAT_W'(-diff) : FEAT_W'(diff);
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= feed.valid;
            v2_reg <= v1_reg;
        end
    end

    // square then saturating accumulate
    assign acc_sum = {1'b0, acc_reg} + {1'b0, sq_reg};

    always_ff @(posedge clk)
    begin
        mag_reg <= mag[31:0];
        sq_reg  <= mag_reg * mag_reg;
        if (feed.clr)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_sum[DIST_W] ? '1 : acc_sum[DIST_W-1:0];
        end
    end

    // compare against the candidate from the left neighbor
    always_comb
    begin
        own.valid = 1'b1;
        own.score = acc_reg;
        own.idx   = cell_id;
        own.blue  = center_reg[DIM_BLUE];
        own.green = center_reg[DIM_GREEN];
        own.red   = center_reg[DIM_RED];
        take_own  = ({1'b0, cell_id} < n_eff) &&
                    (!chain_in.valid || (acc_reg < chain_in.score));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= '0;
        end
        else if (chain_en)
        begin
            chain_reg <= take_own ? own : chain_in;
        end
    end

    assign chain_out = chain_reg;

endmodule

### hw/rtl/nearest_center_pixel_classifier.sv
// top level of the nearest center pixel classifier: control, dividers, cell chain
// depends on ncpc_pkg, ncpc_div, ncpc_cell and the assertion header
//
//  port group   dir  beat contents
//  s_axis       in   tuser: req_type; tdata: blue, green, red, col, row,
//                    load_index, load_component, load_value
//  m_axis       out  tdata: out_blue, out_green, out_red, nearest_center
//  cfg          in   cfg_we, cfg_index, cfg_wdata; one register per write
//
// a load beat is taken in idle; a pixel beat passes from its accept through the
// coordinate dividers, the distance pipeline, the cell chain and the color
// dividers, then loads the output register and goes back to idle.
// one pixel is in flight at a time; a new beat is taken while a result waits,
// and a stalled result holds the next pixel in the output state.
// rst_n resets control and the configuration registers; center storage is undefined until loaded.
module nearest_center_pixel_classifier (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // blue, green, red, col, row, load_index,
                                       // load_component, load_value, pad
    input  logic        s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // out_blue, out_green, out_red, nearest_center, pad
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import ncpc_pkg::*;

    `include "nearest_center_pixel_classifier_assert.svh"

    // input fields
    logic [7:0]         in_blue, in_green, in_red;
    logic [11:0]        in_col, in_row;
    logic [IDX_W-1:0]   in_load_index;
    logic [DIM_W-1:0]   in_load_comp;
    logic signed [31:0] in_load_value;

    assign in_blue       = s_axis_tdata[7:0];
    assign in_green      = s_axis_tdata[15:8];
    assign in_red        = s_axis_tdata[23:16];
    assign in_col        = s_axis_tdata[35:24];
    assign in_row        = s_axis_tdata[47:36];
    assign in_load_index = s_axis_tdata[51:48];
    assign in_load_comp  = s_axis_tdata[54:52];
    assign in_load_value = s_axis_tdata[86:55];

    // configuration registers
    logic [15:0] color_scale_reg, spatial_scale_reg;
    logic [12:0] frame_width_reg, frame_height_reg;
    logic [4:0]  center_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_scale_reg   <= 16'd256;
            spatial_scale_reg <= 16'd256;
            frame_width_reg   <= 13'd640;
            frame_height_reg  <= 13'd480;
            center_count_reg  <= 5'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COLOR_SCALE:   color_scale_reg   <= cfg_wdata;
                REG_SPATIAL_SCALE: spatial_scale_reg <= cfg_wdata;
                REG_FRAME_WIDTH:   frame_width_reg   <= cfg_wdata[12:0];
                REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_wdata[12:0];
                REG_CENTER_COUNT:  center_count_reg  <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // effective settings with zero and overflow cases folded in
    logic [15:0]      cs_eff;
    logic [12:0]      w_eff, h_eff;
    logic [CNT_W-1:0] n_eff;

    always_comb
    begin
        cs_eff = (color_scale_reg == 16'd0) ? 16'd1 : color_scale_reg;
        w_eff  = (frame_width_reg == 13'd0) ? 13'd1 : frame_width_reg;
        h_eff  = (frame_height_reg == 13'd0) ? 13'd1 : frame_height_reg;
        if (center_count_reg == 5'd0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (32'(center_count_reg) > MAX_CENTERS)
        begin
            n_eff = CNT_W'(MAX_CENTERS);
        end
        else
        begin
            n_eff = CNT_W'(center_count_reg);
        end
    end

    // control state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             accept, pix_accept, load_accept;
    logic             div_start, xy_start, rgb_start;
    logic             chain_en, out_load, feed_on;
    logic             div_done;
    logic             m_valid_reg;
    logic [31:0]      m_data_reg;
    logic             out_free;

    assign out_free = !m_valid_reg || m_axis_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tuser == REQ_PIXEL)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_DIST;
                end
            end
            S_DIST:
            begin
                if (cnt_reg == CNT_W'(DIST_WAIT))
                begin
                    state_next = S_CHAIN;
                end
            end
            S_CHAIN:
            begin
                if (cnt_reg == CNT_W'(MAX_CENTERS))
                begin
                    state_next = S_OUT_DIV;
                end
            end
            S_OUT_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_axis_tready = (state_reg == S_IDLE);
        accept        = s_axis_tvalid && s_axis_tready;
        pix_accept    = accept && (s_axis_tuser == REQ_PIXEL);
        load_accept   = accept && (s_axis_tuser == REQ_LOAD);
        xy_start      = pix_accept;
        rgb_start     = (state_reg == S_CHAIN) && (cnt_reg == CNT_W'(MAX_CENTERS));
        div_start     = xy_start || rgb_start;
        feed_on       = (state_reg == S_DIST) && (cnt_reg < CNT_W'(FEATURE_DIMS));
        chain_en      = (state_reg == S_CHAIN);
        out_load      = (state_reg == S_OUT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
            begin
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // pixel features
    logic signed [FEAT_W-1:0] feat_reg [FEATURE_DIMS];
    logic [DIV_NUM_W-1:0]     quo [3];
    logic [DIV_NUM_W-1:0]     num [3];
    logic [DIV_DEN_W-1:0]     den [3];
    logic                     done_vec [3];
    chain_t                   tail;

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            feat_reg[DIM_BLUE]  <= FEAT_W'(in_blue) * FEAT_W'(cs_eff);
            feat_reg[DIM_GREEN] <= FEAT_W'(in_green) * FEAT_W'(cs_eff);
            feat_reg[DIM_RED]   <= FEAT_W'(in_red) * FEAT_W'(cs_eff);
        end
        if (state_reg == S_DIV && div_done)
        begin
            feat_reg[DIM_X] <= FEAT_W'(quo[0][27:0]);
            feat_reg[DIM_Y] <= FEAT_W'(quo[1][27:0]);
        end
    end

    // divider operands: coordinates first, then the winner's colors
    always_comb
    begin
        if (xy_start)
        begin
            num[0] = DIV_NUM_W'(in_col) * DIV_NUM_W'(spatial_scale_reg);
            num[1] = DIV_NUM_W'(in_row) * DIV_NUM_W'(spatial_scale_reg);
            num[2] = '0;
            den[0] = DIV_DEN_W'(w_eff);
            den[1] = DIV_DEN_W'(h_eff);
            den[2] = DIV_DEN_W'(1);
        end
        else
        begin
            num[0] = {1'b0, tail.blue[31:0], 1'b0} + DIV_NUM_W'(cs_eff);
            num[1] = {1'b0, tail.green[31:0], 1'b0} + DIV_NUM_W'(cs_eff);
            num[2] = {1'b0, tail.red[31:0], 1'b0} + DIV_NUM_W'(cs_eff);
            den[0] = {cs_eff, 1'b0};
            den[1] = {cs_eff, 1'b0};
            den[2] = {cs_eff, 1'b0};
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        ncpc_div u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .start (div_start),
            .num   (num[g]),
            .den   (den[g]),
            .done  (done_vec[g]),
            .quo   (quo[g])
        );
    end

    assign div_done = done_vec[0];

    // feature broadcast
    feed_t feed;

    always_comb
    begin
        feed.valid = feed_on;
        feed.clr   = pix_accept;
        feed.dim   = cnt_reg[DIM_W-1:0];
        feed.feat  = feat_reg[cnt_reg[DIM_W-1:0] < DIM_W'(FEATURE_DIMS) ?
                              cnt_reg[DIM_W-1:0] : DIM_BLUE];
    end

    // cell chain
    chain_t links [MAX_CENTERS+1];
    assign links[0] = '0;

    for (genvar c = 0; c < MAX_CENTERS; c++)
    begin : g_cell
        ncpc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_id   (IDX_W'(c)),
            .n_eff     (n_eff),
            .wr_en     (load_accept && in_load_index == IDX_W'(c) &&
                        in_load_comp < DIM_W'(FEATURE_DIMS)),
            .wr_comp   (in_load_comp),
            .wr_value  (in_load_value),
            .feed      (feed),
            .chain_en  (chain_en),
            .chain_in  (links[c]),
            .chain_out (links[c+1])
        );
    end

    assign tail = links[MAX_CENTERS];

    // round, clamp and select zero for non-positive colors
    function automatic logic [7:0] to_pixel(input logic signed [31:0] c,
                                            input logic [DIV_NUM_W-1:0] q);
        logic [7:0] r;
        if (c <= 0)
        begin
            r = 8'd0;
        end
        else if (q > DIV_NUM_W'(255))
        begin
            r = 8'd255;
        end
        else
        begin
            r = q[7:0];
        end
        return r;
    endfunction

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= {4'd0, tail.idx, to_pixel(tail.red, quo[2]),
                           to_pixel(tail.green, quo[1]), to_pixel(tail.blue, quo[0])};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // checks
    `NCPC_ASSERT(a_ready_idle, (state_reg != S_IDLE) |-> !s_axis_tready, "ready outside idle")
    `NCPC_ASSERT(a_tail_valid, rgb_start |=> tail.valid, "chain tail empty after search")
    `NCPC_ASSERT(a_div_phase, div_done |-> (state_reg == S_DIV || state_reg == S_OUT_DIV),
                 "divider done out of phase")
    `NCPC_ASSERT(a_div_sync, div_done |-> (done_vec[1] && done_vec[2]), "dividers out of step")
    `NCPC_ASSERT(a_out_free, out_load |=> m_axis_tvalid, "result not presented after load")

endmodule

### verif/tb_top.sv
// self-checking testbench for nearest_center_pixel_classifier: stream driver, result monitor
// and a nearest-center predictor with its own center store; depends on ncpc_pkg and the rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ncpc_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 150;

    typedef struct {
        logic               kind;
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
        logic [11:0]        col;
        logic [11:0]        row;
        logic [3:0]         idx;
        logic [2:0]         comp;
        logic signed [31:0] val;
    } req_t;

    typedef struct {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [3:0] idx;
    } label_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;

    req_t   pending_reqs[$];
    label_t expected_labels[$];
    req_t   cur_req;

    // predictor copy of the block state
    logic signed [31:0] centers[MAX_CENTERS][FEATURE_DIMS];
    logic [15:0] m_color_scale;
    logic [15:0] m_spatial_scale;
    logic [12:0] m_width;
    logic [12:0] m_height;
    logic [4:0]  m_count;

    int errors;
    int pixels_seen;
    int loads_seen;
    int labels_checked;
    int idle_cycles;
    int gap_left;
    int burst_left;
    int stall_mode;
    int stall_phase;

    nearest_center_pixel_classifier u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // center color back to a pixel value, rounded half up and clamped
    function automatic logic [7:0] color_of(logic signed [31:0] c, logic [63:0] s);
        logic [63:0] q;
        if (c <= 0)
            return 8'd0;
        q = (2 * 64'(c) + s) / (2 * s);
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // apply one accepted beat to the predictor
    task automatic classify_or_load(req_t r);
        logic [63:0] cs;
        logic [63:0] w;
        logic [63:0] h;
        int          n;
        longint      feat[FEATURE_DIMS];
        longint      diff;
        logic [63:0] mag;
        logic [63:0] sq;
        logic [63:0] dsum;
        logic [63:0] best_dist;
        int          best;
        label_t      lab;
        if (r.kind == REQ_LOAD)
        begin
            loads_seen++;
            if (r.comp < FEATURE_DIMS)
                centers[r.idx][r.comp] = r.val;
            return;
        end
        pixels_seen++;
        cs = (m_color_scale == 0) ? 64'd1 : 64'(m_color_scale);
        w  = (m_width == 0) ? 64'd1 : 64'(m_width);
        h  = (m_height == 0) ? 64'd1 : 64'(m_height);
        n  = (m_count == 0) ? 1 : ((m_count > MAX_CENTERS) ? MAX_CENTERS : int'(m_count));
        feat[0] = longint'(64'(r.blue) * cs);
        feat[1] = longint'(64'(r.green) * cs);
        feat[2] = longint'(64'(r.red) * cs);
        feat[3] = longint'((64'(r.col) * 64'(m_spatial_scale)) / w);
        feat[4] = longint'((64'(r.row) * 64'(m_spatial_scale)) / h);
        best = 0;
        best_dist = '1;
        for (int ci = 0; ci < n; ci++)
        begin
            dsum = 0;
            for (int d = 0; d < FEATURE_DIMS; d++)
            begin
                diff = feat[d] - longint'(centers[ci][d]);
                mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
                sq   = mag * mag;
                dsum = (dsum > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                             : dsum + sq;
            end
            // lower index keeps the win on a tie
            if (ci == 0 || dsum < best_dist)
            begin
                best_dist = dsum;
                best = ci;
            end
        end
        lab.blue  = color_of(centers[best][DIM_BLUE], cs);
        lab.green = color_of(centers[best][DIM_GREEN], cs);
        lab.red   = color_of(centers[best][DIM_RED], cs);
        lab.idx   = 4'(best);
        expected_labels = {expected_labels, lab};
    endtask

    // sender: bursts of beats with random gaps, predictor fed at each accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            gap_left      <= 0;
            burst_left    <= 4;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                classify_or_load(cur_req);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0 || pending_reqs.size() == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    if (gap_left > 0)
                        gap_left <= gap_left - 1;
                end
                else
                begin
                    cur_req = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= cur_req.kind;
                    s_axis_tdata  <= {1'b0, cur_req.val, cur_req.comp, cur_req.idx,
                                      cur_req.row, cur_req.col, cur_req.red,
                                      cur_req.green, cur_req.blue};
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // receiver stall pattern, switching among four modes picked at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_mode    <= 0;
            stall_phase   <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (stall_phase % 300 == 299)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ((stall_phase % 17) < 9);
            endcase
        end
    end

    // beat monitor, result check and stall watchdog
    always @(posedge clk)
    begin
        label_t want;
        label_t got;
        logic   moved;
        if (rst_n)
        begin
            moved = (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready);
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.blue  = m_axis_tdata[7:0];
                got.green = m_axis_tdata[15:8];
                got.red   = m_axis_tdata[23:16];
                got.idx   = m_axis_tdata[27:24];
                if (expected_labels.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_labels.pop_front();
                    labels_checked++;
                    if (got.blue !== want.blue)
                    begin
                        $display("%0t: out_blue exp %0d got %0d", $time, want.blue, got.blue);
                        errors++;
                    end
                    if (got.green !== want.green)
                    begin
                        $display("%0t: out_green exp %0d got %0d", $time, want.green,
                                 got.green);
                        errors++;
                    end
                    if (got.red !== want.red)
                    begin
                        $display("%0t: out_red exp %0d got %0d", $time, want.red, got.red);
                        errors++;
                    end
                    if (got.idx !== want.idx)
                    begin
                        $display("%0t: nearest_center exp %0d got %0d", $time, want.idx,
                                 got.idx);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // register write, only called while the block is idle
    task automatic write_reg(logic [2:0] index, logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        case (index)
            REG_COLOR_SCALE:   m_color_scale   = value;
            REG_SPATIAL_SCALE: m_spatial_scale = value;
            REG_FRAME_WIDTH:   m_width         = value[12:0];
            REG_FRAME_HEIGHT:  m_height        = value[12:0];
            REG_CENTER_COUNT:  m_count         = value[4:0];
            default: ;
        endcase
        idle_cycles = 0;
    endtask

    task automatic set_regs(int cs, int ss, int w, int h, int n);
        write_reg(REG_COLOR_SCALE, 16'(cs));
        write_reg(REG_SPATIAL_SCALE, 16'(ss));
        write_reg(REG_FRAME_WIDTH, 16'(w));
        write_reg(REG_FRAME_HEIGHT, 16'(h));
        write_reg(REG_CENTER_COUNT, 16'(n));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait for all beats out and results back, then let the pipeline settle
    task automatic drain();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_labels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic add_load(int idx, int comp, logic signed [31:0] val);
        req_t r;
        r = '{kind: REQ_LOAD, blue: 8'($urandom), green: 8'($urandom), red: 8'($urandom),
              col: 12'($urandom), row: 12'($urandom), idx: 4'(idx), comp: 3'(comp),
              val: val};
        pending_reqs = {pending_reqs, r};
    endtask

    task automatic add_pixel(int b, int g, int rd, int col, int row);
        req_t r;
        r = '{kind: REQ_PIXEL, blue: 8'(b), green: 8'(g), red: 8'(rd), col: 12'(col),
              row: 12'(row), idx: 4'($urandom), comp: 3'($urandom), val: 32'($urandom)};
        pending_reqs = {pending_reqs, r};
    endtask

    // plausible center component for the current scales, with some wild values
    function automatic logic signed [31:0] center_value(int comp);
        int cs;
        cs = (m_color_scale == 0) ? 1 : int'(m_color_scale);
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return -$signed(32'($urandom_range(0, 70000)));
            default:
                if (comp < 3)
                    return $urandom_range(0, 255) * cs + $urandom_range(0, cs);
                else
                    return $urandom_range(0, int'(m_spatial_scale) + 1);
        endcase
    endfunction

    task automatic load_centers(int count);
        for (int c = 0; c < count; c++)
            for (int d = 0; d < FEATURE_DIMS; d++)
                add_load(c, d, center_value(d));
    endtask

    // random phase: mostly pixels, with loads and ignored loads mixed in
    task automatic random_phase(int items);
        for (int i = 0; i < items; i++)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 4) == 0)
                    add_pixel($urandom, $urandom, $urandom, $urandom, $urandom);
                else
                    add_pixel($urandom, $urandom, $urandom,
                              $urandom_range(0, (m_width == 0) ? 0 : m_width - 1),
                              $urandom_range(0, (m_height == 0) ? 0 : m_height - 1));
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                add_load($urandom_range(0, 15), $urandom_range(5, 7), $urandom);
            end
            else
            begin
                add_load($urandom_range(0, 15), $urandom_range(0, 4),
                         center_value($urandom_range(0, 4)));
            end
        end
        drain();
    endtask

    initial
    begin
        errors = 0;
        pixels_seen = 0;
        loads_seen = 0;
        labels_checked = 0;
        idle_cycles = 0;
        cfg_we = 1'b0;
        cfg_index = REG_COLOR_SCALE;
        cfg_wdata = '0;
        m_color_scale = 16'd256;
        m_spatial_scale = 16'd256;
        m_width = 13'd640;
        m_height = 13'd480;
        m_count = 5'd1;
        for (int c = 0; c < MAX_CENTERS; c++)
            for (int d = 0; d < FEATURE_DIMS; d++)
                centers[c][d] = 0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every center defined, ties, clamps, ignored loads, edge pixels
        set_regs(256, 256, 640, 480, 16);
        load_centers(MAX_CENTERS);
        for (int d = 0; d < FEATURE_DIMS; d++)
        begin
            add_load(0, d, 32'sd1000);
            add_load(1, d, 32'sd1000);
        end
        add_load(15, DIM_BLUE, 32'sh7FFF_FFFF);
        add_load(15, DIM_GREEN, 32'sh8000_0000);
        add_load(2, 5, 32'sh1234_5678);
        add_load(3, 7, 32'shFFFF_FFFF);
        add_pixel(4, 4, 4, 4, 4);
        add_pixel(0, 0, 0, 0, 0);
        add_pixel(255, 255, 255, 4095, 4095);
        add_pixel(255, 0, 128, 639, 479);
        add_pixel(0, 255, 0, 4095, 0);
        drain();

        // settings across the register extremes
        set_regs(0, 65535, 1, 1, 0);
        random_phase(35);
        set_regs(65535, 0, 4096, 4096, 31);
        load_centers(4);
        random_phase(35);
        set_regs(512, 1024, 100, 60, 5);
        load_centers(5);
        random_phase(40);
        set_regs(128, 2000, 8191, 0, 16);
        random_phase(40);
        set_regs($urandom_range(1, 65535), $urandom_range(0, 65535),
                 $urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(1, 16));
        load_centers(16);
        random_phase(40);
        set_regs(256, 256, 640, 480, $urandom_range(2, 16));
        random_phase(40);

        $display("covered %0d pixel beats and %0d load beats, %0d results checked",
                 pixels_seen, loads_seen, labels_checked);
        $display("over seven register settings including zero and full-scale values");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/ncpc_pkg.sv
hw/rtl/ncpc_div.sv
hw/rtl/ncpc_cell.sv
hw/rtl/nearest_center_pixel_classifier.sv
verif/tb_top.sv
